### rtl/core/jqve_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jqve_pkg
// Shared types, character codes and lookup functions for the quoted JSON
// value encoder.
// ----------------------------------------------------------------------------
package jqve_pkg;

   localparam int MAX_CHARS   = 6;   // most characters one request can cause
   localparam int LEN_W       = 3;   // holds 0..MAX_CHARS
   localparam int COUNT_W     = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] OP_TEXT   = 2'd0;
   localparam logic [1:0] OP_BASE64 = 2'd1;
   localparam logic [1:0] OP_HEX    = 2'd2;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_PAD       = 8'h3D;  // '='
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LOW_B     = 8'h62;  // 'b'
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_LOW_A     = 8'h61;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_SLASH     = 8'h2F;

   // One request's worth of characters, queued between front and back
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [LEN_W-1:0]          len;
      logic [COUNT_W-1:0]        base_count;
   } jqve_entry_type;

   // Standard base64 alphabet
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26)
         r = CH_UP_A + {2'b00, v};
      else if (v < 6'd52)
         r = CH_LOW_A + {2'b00, v - 6'd26};
      else if (v < 6'd62)
         r = CH_ZERO + {2'b00, v - 6'd52};
      else if (v == 6'd62)
         r = CH_PLUS;
      else
         r = CH_SLASH;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10)
         r = CH_ZERO + {4'h0, v};
      else
         r = CH_LOW_A + {4'h0, v - 4'd10};
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/jqve_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jqve_front
// Classifies each request, expands it into its character group, keeps the
// base64 group state and the running character count.
// ----------------------------------------------------------------------------
module jqve_front
   import jqve_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic           csr_wr_data,
   input  wire logic           req_accept,
   input  wire logic [1:0]     req_operation,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic           req_first_byte,
   input  wire logic           req_last_byte,
   input  wire logic           req_empty_value,
   output logic                push,
   output jqve_entry_type      push_entry
);

   logic               emit_enable_ff, emit_enable_in;
   logic [1:0]         phase_ff, phase_in;
   logic [3:0]         left_ff, left_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [MAX_CHARS-1:0][7:0] seq;
   logic [LEN_W-1:0]          n;
   logic [1:0]                ph;
   logic [3:0]                lf;
   logic [7:0]                c;
   logic [7:0]                esc;

   always_comb begin
      seq      = '0;
      n        = '0;
      phase_in = phase_ff;
      left_in  = left_ff;
      c        = req_data_byte;
      esc      = 8'h00;
      ph       = phase_ff;
      lf       = left_ff;
      if (req_empty_value) begin
         seq[n] = CH_QUOTE; n = n + 1'b1;
         seq[n] = CH_QUOTE; n = n + 1'b1;
         phase_in = 2'd0;
         left_in  = 4'd0;
      end else begin
         if (req_first_byte) begin
            seq[n] = CH_QUOTE; n = n + 1'b1;
            if (req_operation == OP_BASE64) begin
               ph = 2'd0;
               lf = 4'd0;
            end
         end
         case (req_operation)
            OP_TEXT: begin
               case (c)
                  CH_QUOTE:     esc = CH_QUOTE;
                  CH_BACKSLASH: esc = CH_BACKSLASH;
                  CH_BS:        esc = CH_LOW_B;
                  CH_FF:        esc = CH_LOW_F;
                  CH_LF:        esc = CH_LOW_N;
                  CH_CR:        esc = CH_LOW_R;
                  CH_TAB:       esc = CH_LOW_T;
                  default:      esc = 8'h00;
               endcase
               if (esc != 8'h00) begin
                  seq[n] = CH_BACKSLASH; n = n + 1'b1;
                  seq[n] = esc;          n = n + 1'b1;
               end else begin
                  seq[n] = c; n = n + 1'b1;
               end
            end
            OP_BASE64: begin
               if (ph == 2'd0) begin
                  seq[n] = b64_char(c[7:2]); n = n + 1'b1;
                  lf = {2'b00, c[1:0]};
                  ph = 2'd1;
               end else if (ph == 2'd1) begin
                  seq[n] = b64_char({lf[1:0], c[7:4]}); n = n + 1'b1;
                  lf = c[3:0];
                  ph = 2'd2;
               end else begin
                  seq[n] = b64_char({lf, c[7:6]}); n = n + 1'b1;
                  seq[n] = b64_char(c[5:0]);       n = n + 1'b1;
                  lf = 4'd0;
                  ph = 2'd0;
               end
               if (req_last_byte) begin
                  // flush the partial group with padding
                  if (ph == 2'd1) begin
                     seq[n] = b64_char({lf[1:0], 4'b0000}); n = n + 1'b1;
                     seq[n] = CH_PAD; n = n + 1'b1;
                     seq[n] = CH_PAD; n = n + 1'b1;
                  end else if (ph == 2'd2) begin
                     seq[n] = b64_char({lf, 2'b00}); n = n + 1'b1;
                     seq[n] = CH_PAD; n = n + 1'b1;
                  end
                  ph = 2'd0;
                  lf = 4'd0;
               end
               phase_in = ph;
               left_in  = lf;
            end
            OP_HEX: begin
               seq[n] = hex_char(c[7:4]); n = n + 1'b1;
               seq[n] = hex_char(c[3:0]); n = n + 1'b1;
            end
            default: begin
            end
         endcase
         if (req_last_byte) begin
            seq[n] = CH_QUOTE; n = n + 1'b1;
         end
      end
   end

   assign emit_enable_in = csr_wr_en ? csr_wr_data : emit_enable_ff;
   assign count_in       = count_ff + {{(COUNT_W-LEN_W){1'b0}}, n};

   assign push                  = req_accept && emit_enable_ff && (n != '0);
   assign push_entry.chars      = seq;
   assign push_entry.len        = n;
   assign push_entry.base_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_enable_ff <= 1'b1;
         phase_ff       <= 2'd0;
         left_ff        <= 4'd0;
         count_ff       <= '0;
      end else begin
         emit_enable_ff <= emit_enable_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            count_ff <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/jqve_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jqve_queue
// Short queue of character groups between the front and the back.
// ----------------------------------------------------------------------------
module jqve_queue
   import jqve_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire jqve_entry_type push_entry,
   input  wire logic           pop,
   output jqve_entry_type      head,
   output logic                not_empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jqve_entry_type   mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         fill_in = fill_ff + 1'b1;
      else if (pop && !push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/jqve_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jqve_back
// Walks the head character group into the output register one character per
// cycle while rsp_tready does not stall it, and stamps each character with its running count.
// ----------------------------------------------------------------------------
module jqve_back
   import jqve_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire jqve_entry_type head,
   input  wire logic           not_empty,
   output logic                pop,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tlast
);

   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               load;
   logic               last_char;

   assign load      = not_empty && (!valid_ff || rsp_tready);
   assign last_char = (idx_ff == head.len - 1'b1);
   assign pop       = load && last_char;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      char_in  = char_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = head.chars[idx_ff];
         last_in  = last_char;
         count_in = head.base_count + {{(COUNT_W-LEN_W){1'b0}}, idx_ff} + 1'b1;
         idx_in   = last_char ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {count_ff, char_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

### rtl/core/json_quoted_value_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_quoted_value_encoder_core
// Encodes a byte stream as a quoted JSON string: escaped text, base64 or hex.
// ----------------------------------------------------------------------------
// Each request carries one byte of a value and yields zero to six characters
// (quotes, escapes, base64 digits and padding, hex digits). A request is taken
// whenever the group queue has room; characters leave one per cycle from the
// output register while rsp_tready is high, each passing first through the group
// queue and then the output register. The output side sets the sustained rate:
// a request of n characters holds the back end until all n have left, and the
// QUEUE_DEPTH-entry queue absorbs bursts. With csr_wr_data low at a csr_wr_en
// pulse, characters are counted but not sent.
// ----------------------------------------------------------------------------
module json_quoted_value_encoder_core
   import jqve_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,   // emit_enable
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] data_byte
   input  wire logic [3:0]  req_tuser,     // [1:0] operation, [2] first_byte, [3] empty_value
   input  wire logic        req_tlast,     // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,     // [7:0] out_char, [39:8] char_count
   output logic             rsp_tlast      // last_out
);

   logic           q_full;
   logic           q_not_empty;
   logic           push;
   logic           pop;
   logic           req_accept;
   jqve_entry_type push_entry;
   jqve_entry_type head;

   assign req_tready = !q_full;
   assign req_accept = req_tvalid && !q_full;

   jqve_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_accept      (req_accept),
      .req_operation   (req_tuser[1:0]),
      .req_data_byte   (req_tdata),
      .req_first_byte  (req_tuser[2]),
      .req_last_byte   (req_tlast),
      .req_empty_value (req_tuser[3]),
      .push            (push),
      .push_entry      (push_entry)
   );

   jqve_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   jqve_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (q_not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
